// ===== rtl/pic_pkg.sv =====
// Package: constants, types and control structs of the interrupt controller.
package pic_pkg;
    localparam int NumSources   = 31;
    localparam int PrioBits     = 3;
    localparam int NumContexts  = 2;
    localparam int SrcSlots     = NumSources + 1;
    localparam int IdBits       = $clog2(SrcSlots);
    localparam int CtxBits      = (NumContexts > 1) ? $clog2(NumContexts) : 1;

    localparam logic [1:0] ActRead  = 2'd0;
    localparam logic [1:0] ActWrite = 2'd1;
    localparam logic [1:0] ActReq   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture transaction, apply its register and request effects
        logic scan_clr;  // reset scan index and best trackers
        logic scan_step; // examine one source for every context
        logic finish;    // commit claim, build result
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;
    } status_t;
endpackage

// ===== rtl/platform_interrupt_controller_core.sv =====
// Top level of the platform interrupt controller core.
// An accepted transaction scans all 31 sources, then commits its result to the output
// register; s_tready stays low until that commit, so one transaction is in flight at a time.
// The per-source scan, one source per cycle, sets the rate; a result not taken holds commit.
// Reset: asynchronous active-low rst_n clears all priorities, pending,
// in-service, enable and threshold registers and empties the output stage.
module platform_interrupt_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] action, [27:2] reg_offset, [59:28] write_data, [64:60] source_id
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_data, [32] access_error, [34:33] context_irq
    output logic [39:0] m_tdata
);
    pic_pkg::cmd_t    cmd;
    pic_pkg::status_t status;
    logic [31:0] r_rd;
    logic        r_err;
    logic [1:0]  r_irq;
    logic        out_valid_reg;
    logic [34:0] out_data_reg;
    logic        in_fire;

    assign in_fire = s_tvalid && s_tready;

    pic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_valid_reg && !m_tready),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    pic_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .action           (s_tdata[1:0]),
        .reg_offset       (s_tdata[27:2]),
        .write_data       (s_tdata[59:28]),
        .source_id        (s_tdata[64:60]),
        .status           (status),
        .res_read_data    (r_rd),
        .res_access_error (r_err),
        .res_context_irq  (r_irq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= {r_irq, r_err, r_rd};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg};

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result overwrote a pending output");
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !cmd.scan_step && !cmd.finish)
        else $error("input ready while busy");
    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_tvalid)
        else $error("result not presented");
endmodule

// ===== rtl/pic_ctrl.sv =====
// Controller state machine: sequences capture, source scan and result.
module pic_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_busy,
    input  pic_pkg::status_t  status,
    output pic_pkg::cmd_t     cmd,
    output logic              in_ready
);
    pic_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pic_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            pic_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = pic_pkg::ST_SCAN;
                end
            end
            pic_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = pic_pkg::ST_DONE;
                end
            end
            pic_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = pic_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pic_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/pic_datapath.sv =====
// Datapath: register file, sequential priority scan and result formation.
module pic_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  pic_pkg::cmd_t     cmd,
    input  logic [1:0]        action,
    input  logic [25:0]       reg_offset,
    input  logic [31:0]       write_data,
    input  logic [4:0]        source_id,
    output pic_pkg::status_t  status,
    output logic [31:0]       res_read_data,
    output logic              res_access_error,
    output logic [1:0]        res_context_irq
);
    localparam int NS = pic_pkg::NumSources;
    localparam int NC = pic_pkg::NumContexts;
    localparam int PB = pic_pkg::PrioBits;
    localparam int IB = pic_pkg::IdBits;
    localparam int CB = pic_pkg::CtxBits;

    logic [PB-1:0] prio_reg [pic_pkg::SrcSlots];
    logic [NS:1]   pend_reg;
    logic [NS:1]   insvc_reg;
    logic [NS:1]   enab_reg [NC];
    logic [PB-1:0] thr_reg  [NC];

    logic          claim_reg;
    logic [pic_pkg::CtxBits-1:0] claim_ctx_reg;
    logic [31:0]   rd_reg;
    logic          err_reg;

    logic [IB-1:0] idx_reg;
    logic [IB-1:0] best_id_reg   [NC];
    logic [PB-1:0] best_prio_reg [NC];
    logic          more_reg      [NC];

    // decode of the incoming transaction
    logic          is_rd, is_wr, d_err;
    logic [31:0]   d_rd;
    logic          d_claim;
    logic          d_thr_wr;
    logic [pic_pkg::CtxBits-1:0] d_ctx;
    logic [25:0]   rel_enab, rel_ctx;
    logic [IB-1:0] pid;

    always_comb
    begin
        is_rd    = (action == pic_pkg::ActRead);
        is_wr    = (action == pic_pkg::ActWrite);
        d_err    = 1'b0;
        d_rd     = '0;
        d_claim  = 1'b0;
        d_thr_wr = 1'b0;
        d_ctx    = '0;
        rel_enab = reg_offset - 26'h2000;
        rel_ctx  = reg_offset - 26'h200000;
        pid      = reg_offset[IB+1:2];
        if (is_rd || is_wr)
        begin
            if (reg_offset[1:0] != 2'b00)
            begin
                d_err = 1'b1;
            end
            else if (reg_offset < 26'(4 * pic_pkg::SrcSlots))
            begin
                if (pid == '0)
                begin
                    d_err = is_wr;
                end
                else
                begin
                    d_rd = 32'(prio_reg[pid]);
                end
            end
            else if (reg_offset == 26'h1000)
            begin
                d_err = is_wr;
                if (is_rd)
                begin
                    d_rd = 32'({pend_reg, 1'b0});
                end
            end
            else if (reg_offset >= 26'h2000 && reg_offset < 26'(32'h2000 + 32'h80 * NC))
            begin
                d_ctx = rel_enab[pic_pkg::CtxBits+6:7];
                if (rel_enab[6:2] != 5'd0)
                begin
                    d_err = 1'b1;
                end
                else
                begin
                    d_rd = 32'({enab_reg[d_ctx], 1'b0});
                end
            end
            else if (reg_offset >= 26'h200000 &&
                     reg_offset < 26'(32'h200000 + 32'h1000 * NC))
            begin
                d_ctx = rel_ctx[pic_pkg::CtxBits+11:12];
                if (rel_ctx[11:0] == 12'd0)
                begin
                    d_rd     = 32'(thr_reg[d_ctx]);
                    d_thr_wr = is_wr;
                end
                else if (rel_ctx[11:0] == 12'd4)
                begin
                    d_claim = is_rd;
                end
                else
                begin
                    d_err = 1'b1;
                end
            end
            else
            begin
                d_err = 1'b1;
            end
            if (is_wr)
            begin
                d_rd = '0;
            end
        end
    end

    logic [IB-1:0] cmp_id;
    assign cmp_id = write_data[IB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pic_pkg::SrcSlots; i++)
            begin
                prio_reg[i] <= '0;
            end
            pend_reg  <= '0;
            insvc_reg <= '0;
            for (int c = 0; c < NC; c++)
            begin
                enab_reg[c] <= '0;
                thr_reg[c]  <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                if (action == pic_pkg::ActReq && source_id != 5'd0 &&
                    32'(source_id) <= 32'(NS) &&
                    !insvc_reg[source_id[IB-1:0]] && !pend_reg[source_id[IB-1:0]])
                begin
                    pend_reg[source_id[IB-1:0]] <= 1'b1;
                end
                if (is_wr && !d_err)
                begin
                    if (reg_offset < 26'(4 * pic_pkg::SrcSlots))
                    begin
                        prio_reg[pid] <= write_data[PB-1:0];
                    end
                    else if (reg_offset < 26'h200000)
                    begin
                        enab_reg[d_ctx] <= write_data[NS:1];
                    end
                    else if (rel_ctx[11:0] == 12'd0)
                    begin
                        thr_reg[d_ctx] <= write_data[PB-1:0];
                    end
                    else if (write_data != 32'd0 && write_data <= 32'(NS) &&
                             enab_reg[d_ctx][cmp_id])
                    begin
                        insvc_reg[cmp_id] <= 1'b0;
                    end
                end
            end
            if (cmd.finish && claim_reg && best_id_reg[claim_ctx_reg] != '0)
            begin
                pend_reg[best_id_reg[claim_ctx_reg]]  <= 1'b0;
                insvc_reg[best_id_reg[claim_ctx_reg]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            claim_reg     <= d_claim;
            claim_ctx_reg <= d_ctx;
            rd_reg        <= d_rd;
            err_reg       <= d_err;
        end
    end

    // scan one source per cycle for all contexts, strict > keeps lowest ID on ties;
    // more_reg marks a second source above threshold in the context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            for (int c = 0; c < NC; c++)
            begin
                best_id_reg[c]   <= '0;
                best_prio_reg[c] <= '0;
                more_reg[c]      <= 1'b0;
            end
        end
        else if (cmd.scan_clr)
        begin
            idx_reg <= IB'(1);
            for (int c = 0; c < NC; c++)
            begin
                best_id_reg[c] <= '0;
                more_reg[c]    <= 1'b0;
                // start from the threshold this transaction leaves behind
                if (d_thr_wr && d_ctx == CB'(c))
                begin
                    best_prio_reg[c] <= write_data[PB-1:0];
                end
                else
                begin
                    best_prio_reg[c] <= thr_reg[c];
                end
            end
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + IB'(1);
            for (int c = 0; c < NC; c++)
            begin
                if (pend_reg[idx_reg] && enab_reg[c][idx_reg] &&
                    prio_reg[idx_reg] > best_prio_reg[c])
                begin
                    best_id_reg[c]   <= idx_reg;
                    best_prio_reg[c] <= prio_reg[idx_reg];
                end
                if (pend_reg[idx_reg] && enab_reg[c][idx_reg] &&
                    prio_reg[idx_reg] > thr_reg[c] && best_id_reg[c] != '0)
                begin
                    more_reg[c] <= 1'b1;
                end
            end
        end
    end

    assign status.scan_last = (32'(idx_reg) == 32'(NS));

    // irq after this step: a claimed winner leaves every context it won with the runner-up, if any
    always_comb
    begin
        res_read_data    = rd_reg;
        res_access_error = err_reg;
        if (claim_reg)
        begin
            res_read_data = 32'(best_id_reg[claim_ctx_reg]);
        end
        res_context_irq = '0;
        for (int c = 0; c < NC && c < 2; c++)
        begin
            res_context_irq[c] = (best_id_reg[c] != '0);
            if (claim_reg && best_id_reg[claim_ctx_reg] != '0 &&
                best_id_reg[c] == best_id_reg[claim_ctx_reg])
            begin
                res_context_irq[c] = more_reg[c];
            end
        end
    end
endmodule
